[rtl/core/dlfb_pkg.sv]
// dlfb_pkg: widths, codes, fsm type and saturation helper of the dense layer block
// no dependencies; used by the channel interfaces and the top level
`default_nettype none
package dlfb_pkg;

    localparam int DEF_MAX_INPUTS  = 16;
    localparam int DEF_MAX_NEURONS = 16;
    localparam int DEF_MAX_SAMPLES = 8;
    localparam int DEF_DATA_WIDTH  = 16;

    localparam int MODE_W     = 3;
    localparam int SMP_W      = 3;
    localparam int IDX_W      = 4;
    localparam int VAL_W      = 16;
    localparam int KIND_W     = 2;
    localparam int RES_W      = 32;
    localparam int CNT_W      = 5;
    localparam int COEF_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_BITS  = 8;
    localparam int ACC_W      = 40;
    localparam int SUM_W      = 42;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int L2P_W      = VAL_W + COEF_W + 2;
    localparam int OUT_MAX    = 2 ** IDX_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_WEIGHT_WR = 3'd0,
        MODE_BIAS_WR   = 3'd1,
        MODE_FORWARD   = 3'd2,
        MODE_OUT_GRAD  = 3'd3,
        MODE_WGRAD_RD  = 3'd4,
        MODE_BGRAD_RD  = 3'd5
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_FWD    = 2'd0,
        KIND_IN_GRD = 2'd1,
        KIND_W_GRD  = 2'd2,
        KIND_B_GRD  = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUTS_USED  = 3'd0,
        CFG_NEURONS_USED = 3'd1,
        CFG_W_L1         = 3'd2,
        CFG_W_L2         = 3'd3,
        CFG_B_L1         = 3'd4,
        CFG_B_L2         = 3'd5
    } t_cfg_idx;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DOT    = 11'b000_0000_0010,
        S_DRAIN  = 11'b000_0000_0100,
        S_EMIT   = 11'b000_0000_1000,
        S_BRD    = 11'b000_0001_0000,
        S_BWR    = 11'b000_0010_0000,
        S_WG     = 11'b000_0100_0000,
        S_WDRAIN = 11'b000_1000_0000,
        S_RRD    = 11'b001_0000_0000,
        S_RMUL   = 11'b010_0000_0000,
        S_RSUM   = 11'b100_0000_0000
    } t_state;

    function automatic logic signed [RES_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(signed'({1'b0, {(RES_W-1){1'b1}}}));
        lo = SUM_W'(signed'({1'b1, {(RES_W-1){1'b0}}}));
        if (x > hi) return hi[RES_W-1:0];
        if (x < lo) return lo[RES_W-1:0];
        return x[RES_W-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/core/dlfb_in_if.sv]
// dlfb_in_if: input item channel, valid/ready plus the item fields
// depends on dlfb_pkg for field widths
`default_nettype none
interface dlfb_in_if import dlfb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SMP_W-1:0]  sample_index;
    logic [IDX_W-1:0]  feature_index;
    logic [IDX_W-1:0]  neuron_index;
    logic signed [VAL_W-1:0] data_value;

    modport source (output valid, mode, sample_index, feature_index, neuron_index,
                    data_value, input ready);
    modport sink   (input valid, mode, sample_index, feature_index, neuron_index,
                    data_value, output ready);
endinterface
`default_nettype wire

[rtl/core/dlfb_out_if.sv]
// dlfb_out_if: result channel, valid/ready plus the result fields
// depends on dlfb_pkg for field widths
`default_nettype none
interface dlfb_out_if import dlfb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [SMP_W-1:0]  result_sample;
    logic [IDX_W-1:0]  result_index;
    logic signed [RES_W-1:0] result_value;
    logic              last_of_run;

    modport source (output valid, result_kind, result_sample, result_index, result_value,
                    last_of_run, input ready);
    modport sink   (input valid, result_kind, result_sample, result_index, result_value,
                    last_of_run, output ready);
endinterface
`default_nettype wire

[rtl/core/dlfb_ram.sv]
// dlfb_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module dlfb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/core/dense_layer_forward_backward.sv]
// dense_layer_forward_backward: top level, sequencer, shared mac and config registers
// depends on dlfb_pkg, dlfb_in_if, dlfb_out_if and dlfb_ram
`default_nettype none
// Dense layer in Q8.8 with forward pass, gradient accumulation and regularized
// gradient read-out. All state sits in six single-read-port rams; one shared
// 16x16 multiply-accumulate walks them one term per cycle within a pass. Weight
// and bias writes (modes 0, 1) and forward elements that do not close a sample
// are taken without leaving the idle state. The last forward element of a sample
// runs one mac pass per neuron, min(neurons,16) passes. An output-gradient element
// runs the bias and weight gradient read-modify-write, plus one input-gradient pass
// per input, min(inputs,16) passes, when it closes a row. Gradient reads (modes 4,
// 5) step through read, multiply and sum states. The gradient accumulators clear
// at once through per-entry valid bits, so there is no clearing pass. Results leave
// through an output register; a new item is taken while the last result still waits.
module dense_layer_forward_backward import dlfb_pkg::*; #(
    parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
    parameter int MAX_NEURONS = DEF_MAX_NEURONS,
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    dlfb_in_if.sink                    i_in,
    dlfb_out_if.source                 o_res
);
    // memory geometry
    localparam int WD   = MAX_INPUTS * MAX_NEURONS;
    localparam int SD   = MAX_SAMPLES * MAX_INPUTS;
    localparam int WA_W = (WD > 1) ? $clog2(WD) : 1;
    localparam int SA_W = (SD > 1) ? $clog2(SD) : 1;
    localparam int NA_W = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    // data field bits that carry the value
    localparam int VW   = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;

    // configuration registers
    logic [CNT_W-1:0]  r_inputs_used, r_neurons_used;
    logic [COEF_W-1:0] r_w_l1, r_w_l2, r_b_l1, r_b_l2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inputs_used  <= CNT_W'(16);
            r_neurons_used <= CNT_W'(16);
            r_w_l1 <= '0;
            r_w_l2 <= '0;
            r_b_l1 <= '0;
            r_b_l2 <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_INPUTS_USED:  r_inputs_used  <= i_cfg_data[CNT_W-1:0];
                CFG_NEURONS_USED: r_neurons_used <= i_cfg_data[CNT_W-1:0];
                CFG_W_L1:         r_w_l1 <= i_cfg_data[COEF_W-1:0];
                CFG_W_L2:         r_w_l2 <= i_cfg_data[COEF_W-1:0];
                CFG_B_L1:         r_b_l1 <= i_cfg_data[COEF_W-1:0];
                CFG_B_L2:         r_b_l2 <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // used counts: zero acts as one, clamp to the stored maximum
    logic [CNT_W-1:0] ni, nn, ni_out, nn_out;
    always_comb begin
        if (r_inputs_used == '0) ni = CNT_W'(1);
        else if (int'(r_inputs_used) > MAX_INPUTS) ni = CNT_W'(MAX_INPUTS);
        else ni = r_inputs_used;
        if (r_neurons_used == '0) nn = CNT_W'(1);
        else if (int'(r_neurons_used) > MAX_NEURONS) nn = CNT_W'(MAX_NEURONS);
        else nn = r_neurons_used;
        // at most one result per index value
        ni_out = (int'(ni) > OUT_MAX) ? CNT_W'(OUT_MAX) : ni;
        nn_out = (int'(nn) > OUT_MAX) ? CNT_W'(OUT_MAX) : nn;
    end

    // item decode
    t_mode                   in_mode;
    logic signed [VAL_W-1:0] in_d;
    logic                    in_acc;
    assign in_mode = t_mode'(i_in.mode);
    assign in_d    = VAL_W'($signed(i_in.data_value[VW-1:0]));
    assign in_acc  = i_in.valid && i_in.ready;

    // sequencer state and latched item
    t_state r_state, n_state;
    t_mode  r_mode;
    t_kind  r_kind;
    logic [SMP_W-1:0] r_s;
    logic [IDX_W-1:0] r_f, r_j;
    logic signed [VAL_W-1:0] r_d;
    logic r_rng;
    logic [CNT_W-1:0] r_k, r_q, r_len, r_cnt;

    // mac pipeline: issue -> p1 (ram data, product) -> p2 (accumulate / write back)
    logic r_p1_vld, r_p1_first, r_p1_last, r_p2_vld, r_p2_first, r_p2_last;
    logic [WA_W-1:0] r_p1_addr, r_p2_addr;
    logic r_p1_wv;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_wg_old;
    logic signed [SUM_W-1:0]  r_base, r_acc;
    logic r_acc_done;
    logic r_rd_wv, r_rd_bv;
    logic signed [L2P_W-1:0] r_l2p;

    // accumulator valid bits, all cleared together at sample 0 / neuron 0
    logic [WD-1:0]          r_wvld;
    logic [MAX_NEURONS-1:0] r_bvld;

    // output register
    logic r_out_vld;
    t_kind r_out_kind;
    logic [SMP_W-1:0] r_out_smp;
    logic [IDX_W-1:0] r_out_idx;
    logic signed [RES_W-1:0] r_out_val;
    logic r_out_last;

    // ram ports
    logic w_we, b_we, x_we, g_we, wa_we, ba_we;
    logic [WA_W-1:0] w_waddr, w_raddr, wa_waddr, wa_raddr;
    logic [NA_W-1:0] b_waddr, b_raddr, g_waddr, g_raddr, ba_waddr, ba_raddr;
    logic [SA_W-1:0] x_waddr, x_raddr;
    logic [VAL_W-1:0] w_rdata, b_rdata, x_rdata, g_rdata;
    logic [ACC_W-1:0] wa_rdata, ba_rdata, wa_wdata, ba_wdata;

    logic in_wr_ok, in_fwd_ok, in_grd_ok;
    always_comb begin
        in_wr_ok  = (int'(i_in.feature_index) < MAX_INPUTS)
                 && (int'(i_in.neuron_index) < MAX_NEURONS);
        in_fwd_ok = (int'(i_in.sample_index) < MAX_SAMPLES)
                 && (int'(i_in.feature_index) < int'(ni));
        in_grd_ok = (int'(i_in.sample_index) < MAX_SAMPLES)
                 && (int'(i_in.neuron_index) < int'(nn));
    end

    // writes taken straight from the accepted transaction
    assign w_we    = in_acc && (in_mode == MODE_WEIGHT_WR) && in_wr_ok;
    assign w_waddr = WA_W'(int'(i_in.feature_index) * MAX_NEURONS + int'(i_in.neuron_index));
    assign b_we    = in_acc && (in_mode == MODE_BIAS_WR)
                  && (int'(i_in.neuron_index) < MAX_NEURONS);
    assign b_waddr = NA_W'(i_in.neuron_index);
    assign x_we    = in_acc && (in_mode == MODE_FORWARD) && in_fwd_ok;
    assign x_waddr = SA_W'(int'(i_in.sample_index) * MAX_INPUTS + int'(i_in.feature_index));
    assign g_we    = in_acc && (in_mode == MODE_OUT_GRAD) && in_grd_ok;
    assign g_waddr = NA_W'(i_in.neuron_index);

    // read addresses follow the sequencer
    always_comb begin
        w_raddr  = '0;
        b_raddr  = NA_W'(r_q);
        x_raddr  = SA_W'(int'(r_s) * MAX_INPUTS + int'(r_k));
        g_raddr  = NA_W'(r_k);
        wa_raddr = WA_W'(int'(r_k) * MAX_NEURONS + int'(r_j));
        ba_raddr = NA_W'(r_j);
        if (r_state == S_DOT) begin
            if (r_kind == KIND_FWD) w_raddr = WA_W'(int'(r_k) * MAX_NEURONS + int'(r_q));
            else w_raddr = WA_W'(int'(r_q) * MAX_NEURONS + int'(r_k));
        end else if (r_state == S_RRD) begin
            w_raddr  = WA_W'(int'(r_f) * MAX_NEURONS + int'(r_j));
            wa_raddr = w_raddr;
            b_raddr  = NA_W'(r_j);
        end
    end

    // gradient write backs
    assign ba_we    = (r_state == S_BWR);
    assign ba_waddr = NA_W'(r_j);
    assign ba_wdata = (r_rd_bv ? ba_rdata : ACC_W'(0))
                    + (ACC_W'(r_d) <<< FRAC_BITS);
    assign wa_we    = r_p2_vld && ((r_state == S_WG) || (r_state == S_WDRAIN));
    assign wa_waddr = r_p2_addr;
    assign wa_wdata = r_wg_old + ACC_W'(r_prod);

    dlfb_ram #(.WIDTH(VAL_W), .DEPTH(WD)) u_weight (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(in_d),
        .i_raddr(w_raddr), .o_rdata(w_rdata));
    dlfb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NEURONS)) u_bias (
        .i_clk, .i_we(b_we), .i_waddr(b_waddr), .i_wdata(in_d),
        .i_raddr(b_raddr), .o_rdata(b_rdata));
    dlfb_ram #(.WIDTH(VAL_W), .DEPTH(SD)) u_sample (
        .i_clk, .i_we(x_we), .i_waddr(x_waddr), .i_wdata(in_d),
        .i_raddr(x_raddr), .o_rdata(x_rdata));
    dlfb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NEURONS)) u_row (
        .i_clk, .i_we(g_we), .i_waddr(g_waddr), .i_wdata(in_d),
        .i_raddr(g_raddr), .o_rdata(g_rdata));
    dlfb_ram #(.WIDTH(ACC_W), .DEPTH(WD)) u_wgrad (
        .i_clk, .i_we(wa_we), .i_waddr(wa_waddr), .i_wdata(wa_wdata),
        .i_raddr(wa_raddr), .o_rdata(wa_rdata));
    dlfb_ram #(.WIDTH(ACC_W), .DEPTH(MAX_NEURONS)) u_bgrad (
        .i_clk, .i_we(ba_we), .i_waddr(ba_waddr), .i_wdata(ba_wdata),
        .i_raddr(ba_raddr), .o_rdata(ba_rdata));

    // shared multiplier operands
    logic signed [VAL_W-1:0] mul_a, mul_b;
    logic wg_phase;
    assign wg_phase = (r_state == S_WG) || (r_state == S_WDRAIN);
    always_comb begin
        mul_a = (!wg_phase && r_kind == KIND_IN_GRD) ? signed'(g_rdata) : signed'(x_rdata);
        mul_b = wg_phase ? r_d : signed'(w_rdata);
    end

    // regularizer operands for gradient reads
    logic signed [VAL_W-1:0] rg_v;
    logic signed [SUM_W-1:0] rg_acc, rg_l1;
    logic [COEF_W-1:0]       rg_c1, rg_c2;
    always_comb begin
        if (r_mode == MODE_WGRAD_RD) begin
            rg_v   = signed'(w_rdata);
            rg_acc = r_rd_wv ? SUM_W'(signed'(wa_rdata)) : SUM_W'(0);
            rg_c1  = r_w_l1;
            rg_c2  = r_w_l2;
        end else begin
            rg_v   = signed'(b_rdata);
            rg_acc = r_rd_bv ? SUM_W'(signed'(ba_rdata)) : SUM_W'(0);
            rg_c1  = r_b_l1;
            rg_c2  = r_b_l2;
        end
        // sign term counts zero as positive
        rg_l1 = (rg_v >= 0) ? SUM_W'({1'b0, rg_c1}) : -SUM_W'({1'b0, rg_c1});
    end

    logic out_load, out_take, emit_last;
    assign out_take  = r_out_vld && o_res.ready;
    assign emit_last = (r_kind == KIND_W_GRD) || (r_kind == KIND_B_GRD)
                    || (r_q == r_cnt - CNT_W'(1));
    assign out_load  = (r_state == S_EMIT) && (!r_out_vld || o_res.ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (in_mode)
                        MODE_FORWARD:
                            if (in_fwd_ok && (int'(i_in.feature_index) == int'(ni) - 1))
                                n_state = S_DOT;
                        MODE_OUT_GRAD: if (in_grd_ok) n_state = S_BRD;
                        MODE_WGRAD_RD, MODE_BGRAD_RD: n_state = S_RRD;
                        default: ;
                    endcase
                end
            end
            S_DOT:    if (r_k == r_len - CNT_W'(1)) n_state = S_DRAIN;
            S_DRAIN:  if (r_acc_done) n_state = S_EMIT;
            S_EMIT:   if (out_load) n_state = emit_last ? S_IDLE : S_DOT;
            S_BRD:    n_state = S_BWR;
            S_BWR:    n_state = S_WG;
            S_WG:     if (r_k == r_len - CNT_W'(1)) n_state = S_WDRAIN;
            S_WDRAIN: begin
                if (r_p2_vld && r_p2_last)
                    n_state = (int'(r_j) == int'(nn) - 1) ? S_DOT : S_IDLE;
            end
            S_RRD:    n_state = S_RMUL;
            S_RMUL:   n_state = S_RSUM;
            S_RSUM:   n_state = S_EMIT;
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_p1_vld   <= 1'b0;
            r_p2_vld   <= 1'b0;
            r_acc_done <= 1'b0;
            r_out_vld  <= 1'b0;
            r_wvld     <= '0;
            r_bvld     <= '0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= (r_state == S_DOT) || (r_state == S_WG);
            r_p2_vld <= r_p1_vld;
            // only a dot-product pass marks the sum as done
            if (r_state == S_EMIT) r_acc_done <= 1'b0;
            else if (r_p2_vld && r_p2_last && !wg_phase) r_acc_done <= 1'b1;
            if (out_load) r_out_vld <= 1'b1;
            else if (out_take) r_out_vld <= 1'b0;
            // clear of every gradient accumulator comes first for sample 0, neuron 0
            if (in_acc && in_mode == MODE_OUT_GRAD && in_grd_ok
                    && i_in.sample_index == '0 && i_in.neuron_index == '0) begin
                r_wvld <= '0;
                r_bvld <= '0;
            end else begin
                if (wa_we) r_wvld[wa_waddr] <= 1'b1;
                if (ba_we) r_bvld[ba_waddr] <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_mode <= in_mode;
            r_s    <= i_in.sample_index;
            r_f    <= i_in.feature_index;
            r_j    <= i_in.neuron_index;
            r_d    <= in_d;
            r_k    <= '0;
            unique case (in_mode)
                MODE_FORWARD: begin
                    r_kind <= KIND_FWD;
                    r_q    <= '0;
                    r_len  <= ni;
                    r_cnt  <= nn_out;
                end
                MODE_OUT_GRAD: begin
                    r_kind <= KIND_IN_GRD;
                    r_q    <= '0;
                    r_len  <= ni;
                    r_cnt  <= ni_out;
                end
                MODE_WGRAD_RD: begin
                    r_kind <= KIND_W_GRD;
                    r_q    <= CNT_W'(i_in.neuron_index);
                    r_rng  <= in_wr_ok;
                end
                MODE_BGRAD_RD: begin
                    r_kind <= KIND_B_GRD;
                    r_q    <= CNT_W'(i_in.neuron_index);
                    r_rng  <= int'(i_in.neuron_index) < MAX_NEURONS;
                end
                default: r_q <= '0;
            endcase
        end
        if (r_state == S_DOT || r_state == S_WG) r_k <= r_k + CNT_W'(1);
        // input-gradient pass follows the write back when a row closes
        if (r_state == S_WDRAIN) begin
            r_k   <= '0;
            r_len <= nn;
        end
        if (out_load && !emit_last) begin
            r_q <= r_q + CNT_W'(1);
            r_k <= '0;
        end

        // issue stage
        r_p1_first <= (r_k == '0);
        r_p1_last  <= (r_k == r_len - CNT_W'(1));
        r_p1_addr  <= wa_raddr;
        r_p1_wv    <= r_wvld[wa_raddr];
        // ram data stage
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_addr  <= r_p1_addr;
        r_prod     <= mul_a * mul_b;
        r_wg_old   <= r_p1_wv ? signed'(wa_rdata) : ACC_W'(0);
        if (r_state == S_BRD) r_rd_bv <= r_bvld[ba_raddr];
        if (r_state == S_RRD) begin
            r_rd_wv <= r_wvld[wa_raddr];
            r_rd_bv <= r_bvld[ba_raddr];
        end
        if (r_p1_vld && r_p1_first) begin
            r_base <= (r_kind == KIND_FWD) ? (SUM_W'(signed'(b_rdata)) <<< FRAC_BITS)
                                           : SUM_W'(0);
        end
        // accumulate stage
        if (r_p2_vld && !wg_phase)
            r_acc <= (r_p2_first ? r_base : r_acc) + SUM_W'(r_prod);

        // gradient read: acc + l1 sign term + floor(2*l2*v / 256)
        if (r_state == S_RMUL) begin
            r_base <= rg_acc + rg_l1;
            r_l2p  <= signed'(L2P_W'({1'b0, rg_c2, 1'b0})) * L2P_W'(rg_v);
        end
        if (r_state == S_RSUM)
            r_acc <= r_rng ? (r_base + SUM_W'(r_l2p >>> FRAC_BITS)) : SUM_W'(0);

        if (out_load) begin
            r_out_kind <= r_kind;
            r_out_smp  <= (r_kind == KIND_FWD || r_kind == KIND_IN_GRD) ? r_s : SMP_W'(0);
            r_out_idx  <= r_q[IDX_W-1:0];
            r_out_val  <= sat32(r_acc);
            r_out_last <= emit_last;
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_res.valid         = r_out_vld;
    assign o_res.result_kind   = r_out_kind;
    assign o_res.result_sample = r_out_smp;
    assign o_res.result_index  = r_out_idx;
    assign o_res.result_value  = r_out_val;
    assign o_res.last_of_run   = r_out_last;
endmodule
`default_nettype wire
